### rtl/wvs_pkg.sv
// Package for the working-set clock victim selector.
// Holds sizes, register indexes, opcodes and the control/datapath interface structs.
// No dependencies.
`default_nettype none

package wvs_pkg;

  localparam int MAX_FRAMES = 128;
  localparam int FRAME_W    = $clog2(MAX_FRAMES);
  localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
  localparam int TIME_W     = 32;
  localparam int TAU_W      = 32;
  localparam int NFR_W      = 8;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam int IN_FLD_W     = FRAME_W + TIME_W;
  localparam int IN_TDATA_W   = ((IN_FLD_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((FRAME_W + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] REG_TAU    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES = CFG_IDX_W'(1);

  localparam logic OP_REF = 1'b0;
  localparam logic OP_SEL = 1'b1;

  localparam logic [TAU_W-1:0] TAU_RST    = TAU_W'(49);
  localparam logic [NFR_W-1:0] FRAMES_RST = NFR_W'(128);

  // controller -> datapath
  typedef struct packed {
    logic accept;     // request taken this cycle
    logic scan_init;  // set up the sweep
    logic scan_step;  // one frame issued / evaluated
    logic finish;     // commit victim
    logic load_out;   // move result into the output register
  } wvs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
  } wvs_sts_t;

endpackage

`default_nettype wire

### rtl/wvs_ctrl.sv
// Controller FSM for the working-set clock victim selector.
// Sequences accept, sweep, commit and output; depends on wvs_pkg.
`default_nettype none

module wvs_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  output logic                in_tready,
  input  wire                 in_op,
  output logic                out_tvalid,
  input  wire                 out_tready,
  output wvs_pkg::wvs_cmd_t   cmd,
  input  wvs_pkg::wvs_sts_t   sts
);
  import wvs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_FINISH,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    cmd.accept    = accept;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_op == OP_SEL) ? ST_INIT : ST_DONE;
        end
      end
      ST_INIT: begin
        cmd.scan_init = 1'b1;
        state_nxt     = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        // wait here while the previous result is still unclaimed
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/wvs_dpath.sv
// Datapath for the working-set clock victim selector: config registers, frame
// time memory, referenced bits, sweep pipeline and result register. Uses wvs_pkg.
`default_nettype none

module wvs_dpath (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wvs_pkg::wvs_cmd_t                  cmd,
  output wvs_pkg::wvs_sts_t                  sts,
  input  wire                                in_op,
  input  wire  [wvs_pkg::FRAME_W-1:0]        in_frame,
  input  wire  [wvs_pkg::TIME_W-1:0]         in_now,
  input  wire                                cfg_wr_en,
  input  wire  [wvs_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  wire  [wvs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic [wvs_pkg::FRAME_W-1:0]        res_frame,
  output logic                               res_victim
);
  import wvs_pkg::*;

  // config
  logic [TAU_W-1:0]   tau_r;
  logic [NFR_W-1:0]   frames_r;

  // frame state
  logic [TIME_W-1:0]      time_mem [MAX_FRAMES];
  logic [MAX_FRAMES-1:0]  time_vld_r;
  logic [MAX_FRAMES-1:0]  ref_bits_r;
  logic [FRAME_W-1:0]     scan_start_r;

  // sweep state
  logic [TIME_W-1:0]  now_r;
  logic [CNT_W-1:0]   n_r;
  logic [FRAME_W-1:0] start_r;
  logic [FRAME_W-1:0] issue_ptr_r;
  logic [CNT_W-1:0]   issue_left_r;
  logic               ev_vld_r;
  logic [FRAME_W-1:0] ev_pos_r;
  logic [TIME_W-1:0]  rd_q_r;
  logic               rd_v_r;
  logic               stop_r;
  logic               have_r;
  logic [FRAME_W-1:0] cand_r;
  logic [TIME_W-1:0]  cand_age_r;
  logic [FRAME_W-1:0] res_frame_r;
  logic               res_victim_r;
  logic [FRAME_W-1:0] out_frame_r;
  logic               out_victim_r;

  logic [CNT_W-1:0]   n_eff;
  logic [FRAME_W-1:0] start_eff;
  logic               issue;
  logic [CNT_W-1:0]   ptr_inc;
  logic [FRAME_W-1:0] ptr_next;
  logic               ev_act;
  logic               ev_ref;
  logic [TIME_W-1:0]  ev_time;
  logic [TIME_W-1:0]  ev_age;
  logic               ev_over;
  logic               ev_better;
  logic [FRAME_W-1:0] victim;
  logic [CNT_W-1:0]   victim_inc;
  logic               wr_en;
  logic [FRAME_W-1:0] wr_addr;

  // clamp frame count to 1..MAX_FRAMES
  always_comb begin
    if (frames_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (CNT_W'(frames_r) > CNT_W'(MAX_FRAMES)) begin
      n_eff = CNT_W'(MAX_FRAMES);
    end else begin
      n_eff = CNT_W'(frames_r);
    end
    start_eff = (CNT_W'(scan_start_r) < n_eff) ? scan_start_r : '0;
  end

  assign issue    = cmd.scan_step && (issue_left_r != '0) && !stop_r;
  assign ptr_inc  = CNT_W'(issue_ptr_r) + CNT_W'(1);
  assign ptr_next = (ptr_inc >= n_r) ? '0 : ptr_inc[FRAME_W-1:0];

  assign ev_act    = cmd.scan_step && ev_vld_r && !stop_r;
  assign ev_ref    = ref_bits_r[ev_pos_r];
  assign ev_time   = rd_v_r ? rd_q_r : '0;
  assign ev_age    = now_r - ev_time;
  assign ev_over   = ev_age > tau_r;
  assign ev_better = !have_r || (ev_age > cand_age_r);

  assign victim     = have_r ? cand_r : start_r;
  assign victim_inc = CNT_W'(victim) + CNT_W'(1);

  // one write port: referenced frames during the sweep, victim at commit
  assign wr_en   = (ev_act && ev_ref) || cmd.finish;
  assign wr_addr = cmd.finish ? victim : ev_pos_r;

  assign sts.scan_done = stop_r || ((issue_left_r == '0) && !ev_vld_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      time_mem[wr_addr] <= now_r;
    end
    if (issue) begin
      rd_q_r <= time_mem[issue_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tau_r        <= TAU_RST;
      frames_r     <= FRAMES_RST;
      time_vld_r   <= '0;
      ref_bits_r   <= '0;
      scan_start_r <= '0;
      ev_vld_r     <= 1'b0;
      stop_r       <= 1'b0;
      have_r       <= 1'b0;
      issue_left_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          REG_TAU:    tau_r    <= cfg_wdata[TAU_W-1:0];
          REG_FRAMES: frames_r <= cfg_wdata[NFR_W-1:0];
          default:    ;
        endcase
      end
      if (cmd.accept && (in_op == OP_REF)) begin
        ref_bits_r[in_frame] <= 1'b1;
      end
      if (wr_en) begin
        time_vld_r[wr_addr] <= 1'b1;
      end
      if (cmd.scan_init) begin
        issue_ptr_r  <= start_eff;
        issue_left_r <= n_eff;
        ev_vld_r     <= 1'b0;
        stop_r       <= 1'b0;
        have_r       <= 1'b0;
      end
      if (cmd.scan_step) begin
        ev_vld_r <= issue;
        if (issue) begin
          rd_v_r       <= time_vld_r[issue_ptr_r];
          ev_pos_r     <= issue_ptr_r;
          issue_ptr_r  <= ptr_next;
          issue_left_r <= issue_left_r - CNT_W'(1);
        end
      end
      if (ev_act) begin
        if (ev_ref) begin
          ref_bits_r[ev_pos_r] <= 1'b0;
        end else if (ev_over) begin
          cand_r <= ev_pos_r;
          have_r <= 1'b1;
          stop_r <= 1'b1;
        end else if (ev_better) begin
          cand_r     <= ev_pos_r;
          cand_age_r <= ev_age;
          have_r     <= 1'b1;
        end
      end
      if (cmd.finish) begin
        scan_start_r <= (victim_inc >= n_r) ? '0 : victim_inc[FRAME_W-1:0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      now_r        <= in_now;
      res_victim_r <= 1'b0;
      res_frame_r  <= '0;
    end
    if (cmd.scan_init) begin
      n_r     <= n_eff;
      start_r <= start_eff;
    end
    if (cmd.finish) begin
      res_victim_r <= 1'b1;
      res_frame_r  <= victim;
    end
    if (cmd.load_out) begin
      out_frame_r  <= res_frame_r;
      out_victim_r <= res_victim_r;
    end
  end

  assign res_frame  = out_frame_r;
  assign res_victim = out_victim_r;

endmodule

`default_nettype wire

### rtl/wsclock_victim_select_top.sv
// Top level of the working-set clock victim selector.
// Instantiates wvs_ctrl and wvs_dpath; uses wvs_pkg.
//
//  channel   dir  ports                 contents (low bit first)
//  -------   ---  --------------------  ---------------------------------------
//  in_       in   tvalid/tready/tdata   tdata: frame_index[6:0], now[38:7], pad
//                 tuser                 tuser: opcode (0 reference, 1 select)
//  out_      out  tvalid/tready/tdata   tdata: victim_frame[6:0], pad
//                 tuser                 tuser: is_victim
//  cfg_      in   wr_en/addr/wdata      addr 0 tau, addr 1 frames_in_use
//
// One request at a time. A reference goes from accept straight to the output state;
// a select passes through init, the sweep and commit first, the sweep reading the frame
// time memory one frame per cycle. Either waits there until the output register is free.
// A select ends early at the first unreferenced frame older than tau.
// Synchronous active-low reset restores tau 49, 128 frames, all frames clear.
// A new request is accepted while the previous result waits at the output.
`default_nettype none

module wsclock_victim_select_top (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire  [wvs_pkg::IN_TDATA_W-1:0]      in_tdata,   // frame_index, now, pad
  input  wire                                 in_tuser,   // opcode
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [wvs_pkg::OUT_TDATA_W-1:0]     out_tdata,  // victim_frame, pad
  output logic                                out_tuser,  // is_victim
  input  wire                                 cfg_wr_en,
  input  wire  [wvs_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  wire  [wvs_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import wvs_pkg::*;

  wvs_cmd_t           cmd;
  wvs_sts_t           sts;
  logic [FRAME_W-1:0] res_frame;
  logic               res_victim;

  wvs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  wvs_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_op      (in_tuser),
    .in_frame   (in_tdata[FRAME_W-1:0]),
    .in_now     (in_tdata[FRAME_W +: TIME_W]),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .res_frame  (res_frame),
    .res_victim (res_victim)
  );

  assign out_tdata = OUT_TDATA_W'(res_frame);
  assign out_tuser = res_victim;

endmodule

`default_nettype wire
